// File: rtl/bitmap_page_allocator_top_assert.svh
// Assertion macros for the bitmap page allocator.
// Used by the datapath module; needs a clock and an active-low reset in scope.
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define BPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BPA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bpa_pkg.sv
// Shared types and constants of the bitmap page allocator.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package bpa_pkg;

    // Default sizing
    localparam int DEF_PAGE_SHIFT = 12;
    localparam int DEF_MAX_PAGES  = 32768;

    // Map word and field widths
    localparam int WORD_BITS  = 32;
    localparam int CFG_W      = 16;
    localparam int CNT_W      = 16;
    localparam int ADDR_W     = 32;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 1;

    // Register reset values
    localparam logic [CFG_W-1:0] PAGE_COUNT_RST = 16'd0;
    localparam logic [CFG_W-1:0] RESERVED_RST   = 16'd1024;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED   = 1'b1;

    // Operation codes carried on the input tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_INIT  = 2'd2
    } t_kind;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;       // latch input word
        logic sweep_step;   // write one map word of the sweep
        logic sweep_fill;   // 1: reserved pattern, 0: zeros
        logic init_count;   // load used count with the reserved number
        logic scan_start;   // restart the allocate scan
        logic scan_run;     // advance the allocate scan
        logic alloc_commit; // write back the found word, count up
        logic free_read;    // read the word of the page to free
        logic free_commit;  // clear the page bit, count down
        logic out_load;     // load the result register
        logic res_ok;       // result success flag
        logic res_alloc;    // result carries the allocated address
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic sweep_last;    // sweep is at the last map word
        logic scan_empty;    // no managed pages
        logic scan_hit;      // scan found a free page
        logic scan_miss;     // scan ran past the last word
        logic free_in_range; // page to free lies below the page count
        logic free_marked;   // page to free is marked used
        logic out_free;      // result register can take a word
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/bpa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/bpa_ctrl.sv
// Controller state machine of the bitmap page allocator.
// Depends on bpa_pkg; drives the datapath by t_dp_cmd and reads t_dp_stat.
`default_nettype none

module bpa_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic [bpa_pkg::KIND_W-1:0] i_kind,
    output logic                           o_in_ready,
    input  wire bpa_pkg::t_dp_stat         i_stat,
    output bpa_pkg::t_dp_cmd               o_cmd
);

    import bpa_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_ALLOC_WR,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_RESULT
    } t_state;

    t_state  r_state, n_state;
    logic    r_res_ok, n_res_ok;
    logic    r_res_alloc, n_res_alloc;
    t_dp_cmd cmd;

    // Next state and commands
    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_res_ok    = r_res_ok;
        n_res_alloc = r_res_alloc;
        case (r_state)
            ST_CLEAR: begin
                cmd.sweep_step = 1'b1;
                cmd.sweep_fill = 1'b0;
                if (i_stat.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept  = 1'b1;
                    n_res_ok    = 1'b0;
                    n_res_alloc = 1'b0;
                    case (i_kind)
                        KIND_ALLOC: begin
                            if (i_stat.scan_empty) begin
                                n_state = ST_RESULT;
                            end else begin
                                cmd.scan_start = 1'b1;
                                n_state        = ST_SCAN;
                            end
                        end
                        KIND_FREE: n_state = ST_FREE_RD;
                        KIND_INIT: n_state = ST_INIT;
                        default:   n_state = ST_RESULT;
                    endcase
                end
            end
            ST_INIT: begin
                cmd.sweep_step = 1'b1;
                cmd.sweep_fill = 1'b1;
                if (i_stat.sweep_last) begin
                    cmd.init_count = 1'b1;
                    n_res_ok       = 1'b1;
                    n_state        = ST_RESULT;
                end
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (i_stat.scan_hit) begin
                    n_state = ST_ALLOC_WR;
                end else if (i_stat.scan_miss) begin
                    n_state = ST_RESULT;
                end
            end
            ST_ALLOC_WR: begin
                cmd.alloc_commit = 1'b1;
                n_res_ok         = 1'b1;
                n_res_alloc      = 1'b1;
                n_state          = ST_RESULT;
            end
            ST_FREE_RD: begin
                if (i_stat.free_in_range) begin
                    cmd.free_read = 1'b1;
                    n_state       = ST_FREE_CHK;
                end else begin
                    n_state = ST_RESULT;
                end
            end
            ST_FREE_CHK: begin
                if (i_stat.free_marked) begin
                    cmd.free_commit = 1'b1;
                    n_res_ok        = 1'b1;
                end
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        cmd.res_ok    = r_res_ok;
        cmd.res_alloc = r_res_alloc;
    end

    // Hold state and result flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_res_ok    <= 1'b0;
            r_res_alloc <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_ok    <= n_res_ok;
            r_res_alloc <= n_res_alloc;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cmd      = cmd;

endmodule

`default_nettype wire

// File: rtl/bpa_dp.sv
// Datapath of the bitmap page allocator: map RAM, scan pipeline, counters,
// config registers and result register. Depends on bpa_pkg, bpa_ram and the
// assertion macro header.
`default_nettype none
`include "bitmap_page_allocator_top_assert.svh"

module bpa_dp #(
    parameter int PAGE_SHIFT = bpa_pkg::DEF_PAGE_SHIFT,
    parameter int MAX_PAGES  = bpa_pkg::DEF_MAX_PAGES
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [bpa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bpa_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic [bpa_pkg::ADDR_W-1:0]   i_in_addr,
    input  wire bpa_pkg::t_dp_cmd             i_cmd,
    output bpa_pkg::t_dp_stat                 o_stat,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_out_ok,
    output logic      [bpa_pkg::ADDR_W-1:0]   o_out_addr,
    output logic      [bpa_pkg::CNT_W-1:0]    o_out_used
);

    import bpa_pkg::*;

    localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WC_W      = AW + 1;

    // Config registers
    logic [CFG_W-1:0] r_page_count;
    logic [CFG_W-1:0] r_reserved;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count <= PAGE_COUNT_RST;
            r_reserved   <= RESERVED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PAGE_COUNT: r_page_count <= i_cfg_data;
                CFG_RESERVED:   r_reserved   <= i_cfg_data;
                default:        r_page_count <= r_page_count;
            endcase
        end
    end

    // Saturate both counts at the map capacity
    logic [CFG_W-1:0] lim_pages;
    logic [CFG_W-1:0] res_pages;
    logic [16:0]      words_sum;
    logic [WC_W-1:0]  scan_words;

    assign lim_pages  = (32'(r_page_count) > 32'(MAX_PAGES)) ? CFG_W'(MAX_PAGES)
                                                             : r_page_count;
    assign res_pages  = (32'(r_reserved) > 32'(MAX_PAGES)) ? CFG_W'(MAX_PAGES)
                                                           : r_reserved;
    assign words_sum  = 17'(lim_pages) + 17'd31;
    assign scan_words = WC_W'(words_sum >> 5);

    // Map RAM
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Input word latch
    logic [ADDR_W-1:0] r_in_addr;
    logic [ADDR_W-1:0] free_page;
    logic [AW-1:0]     free_word;
    logic [4:0]        free_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in_addr <= i_in_addr;
        end
    end

    assign free_page = r_in_addr >> PAGE_SHIFT;
    assign free_word = free_page[AW+4:5];
    assign free_bit  = free_page[4:0];

    // Sweep counter for the reset clearing pass and init
    logic [AW-1:0]        r_sw_addr;
    logic                 sweep_last;
    logic [15:0]          sw_word;
    logic [15:0]          res_full;
    logic [WORD_BITS-1:0] sweep_data;

    assign sweep_last = (r_sw_addr == AW'(MAP_WORDS - 1));
    assign sw_word    = 16'(r_sw_addr);
    assign res_full   = {5'd0, res_pages[15:5]};

    always_comb begin
        if (!i_cmd.sweep_fill) begin
            sweep_data = '0;
        end else if (sw_word < res_full) begin
            sweep_data = '1;
        end else if (sw_word == res_full) begin
            sweep_data = ~({WORD_BITS{1'b1}} << res_pages[4:0]);
        end else begin
            sweep_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_addr <= '0;
        end else if (i_cmd.sweep_step) begin
            r_sw_addr <= sweep_last ? '0 : r_sw_addr + AW'(1);
        end
    end

    // Scan pipeline: issue one word read a cycle, evaluate it the next cycle
    logic [WC_W-1:0]      r_rd_word;
    logic                 r_ev_vld;
    logic [WC_W-1:0]      r_ev_word;
    logic                 r_hit;
    logic                 r_miss;
    logic [AW-1:0]        r_found_word;
    logic [4:0]           r_found_bit;
    logic [WORD_BITS-1:0] r_found_data;
    logic [WORD_BITS-1:0] word_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [4:0]           first_bit;
    logic                 ev_last;
    logic                 hit_now;
    logic                 rd_issue;

    assign ev_last = (r_ev_word == scan_words - WC_W'(1));

    // Mask off pages at or above the page count in the last word
    always_comb begin
        if (ev_last && (lim_pages[4:0] != 5'd0)) begin
            word_mask = ~({WORD_BITS{1'b1}} << lim_pages[4:0]);
        end else begin
            word_mask = '1;
        end
    end

    assign free_bits = ~ram_rdata & word_mask;

    // Lowest free bit of the word
    always_comb begin
        first_bit = 5'd0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                first_bit = 5'(b);
            end
        end
    end

    assign hit_now  = r_ev_vld && !r_hit && (|free_bits);
    assign rd_issue = i_cmd.scan_run && !r_hit && (r_rd_word < scan_words);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_word <= '0;
            r_ev_vld  <= 1'b0;
            r_ev_word <= '0;
            r_hit     <= 1'b0;
            r_miss    <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_rd_word <= '0;
            r_ev_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_miss    <= 1'b0;
        end else if (i_cmd.scan_run) begin
            r_ev_vld <= rd_issue;
            if (rd_issue) begin
                r_rd_word <= r_rd_word + WC_W'(1);
                r_ev_word <= r_rd_word;
            end
            if (hit_now) begin
                r_hit <= 1'b1;
            end
            if (r_ev_vld && !r_hit && !(|free_bits) && ev_last) begin
                r_miss <= 1'b1;
            end
        end
    end

    // Hold the found page and its updated word
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_run && hit_now) begin
            r_found_word <= r_ev_word[AW-1:0];
            r_found_bit  <= first_bit;
            r_found_data <= ram_rdata | (WORD_BITS'(1) << first_bit);
        end
    end

    // RAM port selection
    assign ram_raddr = i_cmd.free_read ? free_word : r_rd_word[AW-1:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_sw_addr;
        ram_wdata = sweep_data;
        if (i_cmd.sweep_step) begin
            ram_we = 1'b1;
        end else if (i_cmd.alloc_commit) begin
            ram_we    = 1'b1;
            ram_waddr = r_found_word;
            ram_wdata = r_found_data;
        end else if (i_cmd.free_commit) begin
            ram_we    = 1'b1;
            ram_waddr = free_word;
            ram_wdata = ram_rdata & ~(WORD_BITS'(1) << free_bit);
        end
    end

    // Used page count
    logic [CNT_W-1:0] r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.init_count) begin
            r_used <= res_pages;
        end else if (i_cmd.alloc_commit) begin
            r_used <= r_used + CNT_W'(1);
        end else if (i_cmd.free_commit) begin
            r_used <= r_used - CNT_W'(1);
        end
    end

    // Result register
    logic              r_out_valid;
    logic              r_out_ok;
    logic [ADDR_W-1:0] r_out_addr;
    logic [CNT_W-1:0]  r_out_used;
    logic [ADDR_W-1:0] found_page;
    logic              out_free;

    assign found_page = (ADDR_W'(r_found_word) << 5) | ADDR_W'(r_found_bit);
    assign out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_ok   <= i_cmd.res_ok;
            r_out_addr <= i_cmd.res_alloc ? (found_page << PAGE_SHIFT) : '0;
            r_out_used <= r_used;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_ok    = r_out_ok;
    assign o_out_addr  = r_out_addr;
    assign o_out_used  = r_out_used;

    // Status to the controller
    always_comb begin
        o_stat               = '0;
        o_stat.sweep_last    = sweep_last;
        o_stat.scan_empty    = (lim_pages == '0);
        o_stat.scan_hit      = r_hit;
        o_stat.scan_miss     = r_miss;
        o_stat.free_in_range = (free_page < ADDR_W'(lim_pages));
        o_stat.free_marked   = ram_rdata[free_bit];
        o_stat.out_free      = out_free;
    end

    // Checks
    `BPA_ASSERT_IMP(a_hit_miss_excl, i_clk, i_rst_n, r_hit, !r_miss,
        "scan reported both a hit and a miss")
    `BPA_ASSERT_IMP(a_commit_after_hit, i_clk, i_rst_n, i_cmd.alloc_commit, r_hit,
        "allocate write-back without a found page")
    `BPA_ASSERT_IMP(a_no_result_overwrite, i_clk, i_rst_n, i_cmd.out_load, out_free,
        "result register overwritten while its word is pending")
    `BPA_ASSERT_NXT(a_alloc_counts_up, i_clk, i_rst_n, i_cmd.alloc_commit,
        r_used == $past(r_used) + CNT_W'(1), "used count did not rise on allocate")

endmodule

`default_nettype wire

// File: rtl/bitmap_page_allocator_top.sv
// Bitmap first-fit page allocator, one item at a time. An allocate scans the map for the
// lowest free page, one word read per cycle, and fails when the map is full or holds no
// pages; a free clears a used page bit that lies below the page count; init writes the
// whole map, one word written per cycle, with the reserved pattern; an unknown kind fails.
// Input ready returns the cycle after the result loads; a result left waiting stalls it.
// Synchronous active-low reset clears the map before the first item is taken.
`default_nettype none

module bitmap_page_allocator_top #(
    parameter int PAGE_SHIFT = bpa_pkg::DEF_PAGE_SHIFT,
    parameter int MAX_PAGES  = bpa_pkg::DEF_MAX_PAGES
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration writes
    input  wire logic                          i_cfg_we,
    input  wire logic [bpa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bpa_pkg::CFG_W-1:0]     i_cfg_data,
    // Input stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [31:0]                   s_axis_tdata,  // [31:0] release_addr
    input  wire logic [1:0]                    s_axis_tuser,  // [1:0] kind
    // Output stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [47:0]                   m_axis_tdata,  // [31:0] alloc_addr,
                                                              // [47:32] used_count
    output logic      [0:0]                    m_axis_tuser   // [0] ok
);

    import bpa_pkg::*;

    t_dp_cmd           cmd;
    t_dp_stat          stat;
    logic              out_ok;
    logic [ADDR_W-1:0] out_addr;
    logic [CNT_W-1:0]  out_used;

    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_kind     (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bpa_dp #(
        .PAGE_SHIFT (PAGE_SHIFT),
        .MAX_PAGES  (MAX_PAGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_addr   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_ok    (out_ok),
        .o_out_addr  (out_addr),
        .o_out_used  (out_used)
    );

    // Pack the result word
    assign m_axis_tdata = {out_used, out_addr};
    assign m_axis_tuser = out_ok;

endmodule

`default_nettype wire
